>>> hdl/ipp_pkg.sv
package ipp_pkg;

  // payload widths
  localparam int CH_W     = 8;
  localparam int FAM_W    = 2;
  localparam int STAT_W   = 2;
  localparam int ADDR_W   = 64;
  localparam int GROUP_W  = 16;
  localparam int N_GROUPS = 8;
  localparam int PCNT_W   = 4;

  // address family codes
  localparam logic [FAM_W-1:0] FAM_V4 = 2'd0;
  localparam logic [FAM_W-1:0] FAM_V6 = 2'd1;

  // result status codes
  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_MALFORMED = 2'd1;
  localparam logic [STAT_W-1:0] ST_UNSUP     = 2'd2;

  // character codes
  localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CH_W-1:0] CH_DOT   = 8'h2e;
  localparam logic [CH_W-1:0] CH_COLON = 8'h3a;
  localparam logic [CH_W-1:0] CH_0     = 8'h30;
  localparam logic [CH_W-1:0] CH_9     = 8'h39;
  localparam logic [CH_W-1:0] CH_LA    = 8'h61;
  localparam logic [CH_W-1:0] CH_LF    = 8'h66;
  localparam logic [CH_W-1:0] CH_UA    = 8'h41;
  localparam logic [CH_W-1:0] CH_UF    = 8'h46;

  // one character item held in the input register
  typedef struct packed {
    logic [CH_W-1:0]  ch;
    logic [FAM_W-1:0] address_family;
  } item_t;

  // end-of-string summary from the parser to the result stage
  typedef struct packed {
    logic                              done;
    logic [STAT_W-1:0]                 status;
    logic                              v4;
    logic                              gap;
    logic [PCNT_W-1:0]                 gpos;
    logic [PCNT_W-1:0]                 pcnt;
    logic [N_GROUPS-1:0][GROUP_W-1:0]  groups;
  } result_t;

endpackage

>>> hdl/ipp_in_if.sv
interface ipp_in_if;
  import ipp_pkg::*;

  logic             valid;
  logic             ready;
  logic [CH_W-1:0]  ch;
  logic [FAM_W-1:0] address_family;

  modport source(output valid, ch, address_family, input ready);
  modport sink(input valid, ch, address_family, output ready);
endinterface

>>> hdl/ipp_out_if.sv
interface ipp_out_if;
  import ipp_pkg::*;

  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [ADDR_W-1:0] address_high;
  logic [ADDR_W-1:0] address_low;

  modport source(output valid, status, address_high, address_low, input ready);
  modport sink(input valid, status, address_high, address_low, output ready);
endinterface

>>> hdl/ipp_in_reg.sv
module ipp_in_reg (
  input  logic          clk,
  input  logic          rst,
  ipp_in_if.sink        char_in,
  input  logic          take,
  output logic          hold_valid,
  output ipp_pkg::item_t hold_item
);
  import ipp_pkg::*;

  // register refills as soon as the held item moves on, never during reset
  assign char_in.ready = !rst && (!hold_valid || take);

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (char_in.ready) begin
      hold_valid <= char_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (char_in.ready && char_in.valid) begin
      hold_item.ch             <= char_in.ch;
      hold_item.address_family <= char_in.address_family;
    end
  end
endmodule

>>> hdl/ipp_parse.sv
module ipp_parse (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  ipp_pkg::item_t   item,
  output ipp_pkg::result_t res
);
  import ipp_pkg::*;

  typedef enum logic [1:0] {PH_FIELD, PH_GROUP, PH_SEP, PH_LEAD} phase_t;

  logic [FAM_W-1:0]                 fam_latch;
  logic                             at_start;
  logic                             err, err_next;
  phase_t                           phase, phase_next;
  logic [GROUP_W-1:0]               field, field_next;
  logic [2:0]                       dcnt, dcnt_next;
  logic [PCNT_W-1:0]                pcnt, pcnt_next;
  logic                             gap, gap_next;
  logic [PCNT_W-1:0]                gpos, gpos_next;
  logic [N_GROUPS-1:0][GROUP_W-1:0] groups, groups_next;

  logic [FAM_W-1:0]   fam_eff;
  logic               is_nul, is_dig, is_hex, is_lower, is_upper;
  logic [3:0]         hex_val;
  logic [GROUP_W-1:0] field_dec;
  logic [2:0]         dcnt_inc;
  logic [PCNT_W-1:0]  pcnt_inc;
  logic [2:0]         wr_idx;

  // character classes
  assign is_nul    = (item.ch == CH_NUL);
  assign is_dig    = (item.ch >= CH_0) && (item.ch <= CH_9);
  assign is_lower  = (item.ch >= CH_LA) && (item.ch <= CH_LF);
  assign is_upper  = (item.ch >= CH_UA) && (item.ch <= CH_UF);
  assign is_hex    = is_dig || is_lower || is_upper;
  assign hex_val   = is_dig ? item.ch[3:0] : 4'(item.ch[3:0] + 4'd9);

  assign fam_eff   = at_start ? item.address_family : fam_latch;
  assign field_dec = GROUP_W'((field << 3) + (field << 1) + {12'd0, item.ch[3:0]});
  assign dcnt_inc  = 3'(dcnt + 3'd1);
  assign pcnt_inc  = PCNT_W'(pcnt + 4'd1);
  assign wr_idx    = pcnt[2:0];

  // one character step of the parser
  always_comb begin
    err_next    = err;
    phase_next  = phase;
    field_next  = field;
    dcnt_next   = dcnt;
    pcnt_next   = pcnt;
    gap_next    = gap;
    gpos_next   = gpos;
    groups_next = groups;
    if (!err) begin
      if (fam_eff == FAM_V4) begin
        unique case (phase)
          PH_FIELD: begin
            if (is_dig) begin
              field_next = {12'd0, item.ch[3:0]};
              dcnt_next  = 3'd1;
              phase_next = PH_GROUP;
            end else begin
              err_next = 1'b1;
            end
          end
          PH_GROUP: begin
            if (is_dig) begin
              field_next = field_dec;
              dcnt_next  = dcnt_inc;
              if (dcnt_inc > 3'd3 || field_dec > GROUP_W'(255)) err_next = 1'b1;
            end else if (item.ch == CH_DOT || is_nul) begin
              if ((item.ch == CH_DOT && pcnt >= 4'd3) || (is_nul && pcnt != 4'd3)) begin
                err_next = 1'b1;
              end else begin
                groups_next[wr_idx] = field;
                pcnt_next  = pcnt_inc;
                phase_next = PH_FIELD;
              end
            end else begin
              err_next = 1'b1;
            end
          end
          default: err_next = 1'b1;
        endcase
      end else if (fam_eff == FAM_V6) begin
        unique case (phase)
          PH_FIELD, PH_SEP: begin
            if (is_hex) begin
              field_next = {12'd0, hex_val};
              dcnt_next  = 3'd1;
              phase_next = PH_GROUP;
            end else if (item.ch == CH_COLON) begin
              if (phase == PH_FIELD && !gap) begin
                phase_next = PH_LEAD;
              end else if (gap) begin
                err_next = 1'b1;
              end else begin
                gap_next   = 1'b1;
                gpos_next  = pcnt;
                phase_next = PH_FIELD;
              end
            end else if (is_nul && phase == PH_FIELD && gap) begin
              if (pcnt >= 4'd8) err_next = 1'b1;
            end else begin
              err_next = 1'b1;
            end
          end
          PH_GROUP: begin
            if (is_hex) begin
              field_next = {field[GROUP_W-5:0], hex_val};
              dcnt_next  = dcnt_inc;
              if (dcnt_inc > 3'd4) err_next = 1'b1;
            end else if (item.ch == CH_COLON || is_nul) begin
              if (pcnt >= 4'd8) begin
                err_next = 1'b1;
              end else begin
                groups_next[wr_idx] = field;
                pcnt_next  = pcnt_inc;
                phase_next = PH_SEP;
                // end of string: group count must fit the gap rule
                if (is_nul && (gap ? (pcnt_inc >= 4'd8) : (pcnt_inc != 4'd8))) begin
                  err_next = 1'b1;
                end
              end
            end else begin
              err_next = 1'b1;
            end
          end
          PH_LEAD: begin
            if (item.ch == CH_COLON) begin
              gap_next   = 1'b1;
              gpos_next  = pcnt;
              phase_next = PH_FIELD;
            end else begin
              err_next = 1'b1;
            end
          end
          default: err_next = 1'b1;
        endcase
      end
    end
  end

  // summary for the result stage on the terminating nul
  always_comb begin
    res.done   = step && is_nul;
    res.v4     = (fam_eff == FAM_V4);
    res.gap    = gap_next;
    res.gpos   = gpos_next;
    res.pcnt   = pcnt_next;
    res.groups = groups_next;
    if (fam_eff != FAM_V4 && fam_eff != FAM_V6) begin
      res.status = ST_UNSUP;
    end else if (err_next) begin
      res.status = ST_MALFORMED;
    end else begin
      res.status = ST_OK;
    end
  end

  // parser state, cleared at every string end
  always_ff @(posedge clk) begin
    if (rst) begin
      fam_latch <= FAM_V4;
      at_start  <= 1'b1;
      err       <= 1'b0;
      phase     <= PH_FIELD;
      field     <= '0;
      dcnt      <= '0;
      pcnt      <= '0;
      gap       <= 1'b0;
      gpos      <= '0;
    end else if (step) begin
      if (at_start) fam_latch <= item.address_family;
      if (is_nul) begin
        at_start <= 1'b1;
        err      <= 1'b0;
        phase    <= PH_FIELD;
        field    <= '0;
        dcnt     <= '0;
        pcnt     <= '0;
        gap      <= 1'b0;
        gpos     <= '0;
      end else begin
        at_start <= 1'b0;
        err      <= err_next;
        phase    <= phase_next;
        field    <= field_next;
        dcnt     <= dcnt_next;
        pcnt     <= pcnt_next;
        gap      <= gap_next;
        gpos     <= gpos_next;
      end
    end
  end

  // group store, every group read at the end was written in this string
  always_ff @(posedge clk) begin
    if (step) groups <= groups_next;
  end
endmodule

>>> hdl/ipp_out_reg.sv
module ipp_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  ipp_pkg::result_t res,
  output logic             free,
  ipp_out_if.source        addr_out
);
  import ipp_pkg::*;

  logic [GROUP_W-1:0] g [N_GROUPS];
  logic [ADDR_W-1:0]  hi, lo;

  // expand the gap: head groups, zeros, then the tail groups
  always_comb begin : expand
    logic [2:0] gp;
    logic [2:0] tail;
    logic [2:0] pos;
    logic [2:0] sel;
    gp   = res.gpos[2:0];
    tail = res.gap ? 3'(res.pcnt - res.gpos) : 3'd0;
    for (int i = 0; i < N_GROUPS; i++) begin
      pos = 3'(i);
      sel = 3'(gp + pos + tail);
      if (!res.gap || pos < gp) begin
        g[i] = res.groups[pos];
      end else if ({1'b0, pos} < 4'(4'd8 - {1'b0, tail})) begin
        g[i] = '0;
      end else begin
        g[i] = res.groups[sel];
      end
    end
    if (res.status != ST_OK) begin
      hi = '0;
      lo = '0;
    end else if (res.v4) begin
      hi = {res.groups[0][7:0], res.groups[1][7:0], res.groups[2][7:0],
            res.groups[3][7:0], 32'd0};
      lo = '0;
    end else begin
      hi = {g[0], g[1], g[2], g[3]};
      lo = {g[4], g[5], g[6], g[7]};
    end
  end

  assign free = !addr_out.valid || addr_out.ready;

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      addr_out.valid <= 1'b0;
    end else if (res.done) begin
      addr_out.valid <= 1'b1;
    end else if (addr_out.ready) begin
      addr_out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.done) begin
      addr_out.status       <= res.status;
      addr_out.address_high <= hi;
      addr_out.address_low  <= lo;
    end
  end
endmodule

>>> hdl/ip_address_text_parser_core.sv
// textual ipv4 / ipv6 address parser
//
// char_in carries one character per item together with the address family;
// the family is taken with the first character of each string and a nul
// character ends the string. addr_out carries one item per string: status
// plus the 128-bit address split into address_high and address_low, which
// reads zero unless the status is ok.
//
// a character is held in the input register and parsed on its way into the
// parser state, so a new character is taken every cycle unless a nul waits.
// the result of a string is written to the result register as its nul
// leaves the input register. throughput, with no nul waiting, is one character per cycle.
//
// reset (rst, synchronous) empties both registers and puts the parser at the
// start of a string. if addr_out stalls, the result register holds its item;
// characters other than nul keep flowing, and a nul waits in the input
// register until the result register is free.
module ip_address_text_parser_core (
  input  logic      clk,
  input  logic      rst,
  ipp_in_if.sink    char_in,
  ipp_out_if.source addr_out
);
  import ipp_pkg::*;

  logic    hold_valid;
  item_t   hold_item;
  logic    take;
  logic    free;
  result_t res;

  // a nul moves on only when the result register can take its item
  assign take = hold_valid && ((hold_item.ch != CH_NUL) || free);

  ipp_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .char_in    (char_in),
    .take       (take),
    .hold_valid (hold_valid),
    .hold_item  (hold_item)
  );

  ipp_parse u_parse (
    .clk  (clk),
    .rst  (rst),
    .step (take),
    .item (hold_item),
    .res  (res)
  );

  ipp_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .res      (res),
    .free     (free),
    .addr_out (addr_out)
  );
endmodule
